FILE: hdl/lcgbri_pkg.sv
// Package with the constants and shared types of the bounded 48-bit LCG random block.
package lcgbri_pkg;

  localparam int STATE_W    = 48;
  localparam int VAL_W      = 31;
  localparam int MULT_BITS  = 35;
  localparam int CNT_W      = 6;
  localparam int DRAW_SHIFT = 17;

  localparam logic [MULT_BITS-1:0] LCG_MULT = 35'h5DEECE66D;
  localparam logic [STATE_W-1:0]   LCG_INC  = 48'hB;

  // Request to the shared adder: a + b, or a - b when sub is set.
  typedef struct packed {
    logic [STATE_W-1:0] a;
    logic [STATE_W-1:0] b;
    logic               sub;
  } alu_req_t;

  typedef struct packed {
    logic [STATE_W-1:0] sum;
  } alu_rsp_t;

endpackage

FILE: hdl/lcgbri_if.sv
// Valid/ready channel interfaces for the bound input and the random result.
interface lcgbri_in_if;
  logic                           valid;
  logic                           ready;
  logic [lcgbri_pkg::VAL_W-1:0]   upper_bound;

  modport source (output valid, output upper_bound, input ready);
  modport sink   (input valid, input upper_bound, output ready);
endinterface

interface lcgbri_out_if;
  logic                           valid;
  logic                           ready;
  logic [lcgbri_pkg::VAL_W-1:0]   random_value;
  logic                           bound_error;

  modport source (output valid, output random_value, output bound_error, input ready);
  modport sink   (input valid, input random_value, input bound_error, output ready);
endinterface

FILE: hdl/lcgbri_alu.sv
// Shared 48-bit adder/subtractor used by every arithmetic step of the sequencer except the power-of-two scaling.
module lcgbri_alu (
  input  lcgbri_pkg::alu_req_t req,
  output lcgbri_pkg::alu_rsp_t rsp
);

  logic [lcgbri_pkg::STATE_W-1:0] b_eff;

  assign b_eff   = req.sub ? ~req.b : req.b;
  assign rsp.sum = req.a + b_eff + lcgbri_pkg::STATE_W'(req.sub);

endmodule

FILE: hdl/lcg48_bounded_random_int.sv
// Top level of the bounded random integer generator built on a 48-bit LCG.
//
// Usage: the block takes one bound per beat on in_ch and returns one beat on
// out_ch carrying random_value (0 .. bound-1) and bound_error. A write on
// cfg_we/cfg_wdata reseeds the generator with (seed XOR 0x5DEECE66D); it is
// meant to be issued only while no bound is in flight.
//
// Sequence: a bound of zero or one goes straight to the hand-off and does not
// step the generator. Every generator step runs a shift-add multiply over the
// 35 bits of the multiplier and then the increment, all on the single shared
// 48-bit adder. A power-of-two bound adds a scaling step and the hand-off.
// Other bounds add a restoring remainder over the 31 bits of the draw and a
// subtract-then-add rejection test on the same adder before the hand-off, and
// a rejected draw repeats the generator step, the remainder and the test.
// in_ch is ready only while idle, so no new bound is taken before the last
// result has been handed off.
//
// Reset loads the generator with the state of a zero seed and empties the
// output register. When the receiver stalls, the finished result waits in
// the sequencer until the output register frees, and no new bound is taken.
module lcg48_bounded_random_int (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [lcgbri_pkg::STATE_W-1:0]     cfg_wdata,
  lcgbri_in_if.sink                          in_ch,
  lcgbri_out_if.source                       out_ch
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_INC,
    ST_POW,
    ST_DIV,
    ST_CHK_SUB,
    ST_CHK_ADD,
    ST_DONE
  } state_t;

  localparam logic [lcgbri_pkg::STATE_W-1:0] SEED_XOR =
    lcgbri_pkg::STATE_W'(lcgbri_pkg::LCG_MULT);

  state_t                            state_r;
  logic [lcgbri_pkg::STATE_W-1:0]    lcg_r;
  logic [lcgbri_pkg::STATE_W-1:0]    acc_r;
  logic [lcgbri_pkg::CNT_W-1:0]      cnt_r;
  logic [lcgbri_pkg::VAL_W-1:0]      bound_r;
  logic [lcgbri_pkg::VAL_W-1:0]      bits_r;
  logic [lcgbri_pkg::VAL_W-1:0]      result_r;
  logic                              err_r;
  logic                              pow_r;
  logic                              out_valid_r;
  logic [lcgbri_pkg::VAL_W-1:0]      out_value_r;
  logic                              out_err_r;

  lcgbri_pkg::alu_req_t              alu_req;
  lcgbri_pkg::alu_rsp_t              alu_rsp;

  logic                              in_fire;
  logic                              out_free;
  logic                              in_pow;
  logic                              reject;
  logic [2*lcgbri_pkg::VAL_W-1:0]    scaled;

  lcgbri_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign in_fire             = in_ch.valid && in_ch.ready;
  assign out_free            = !out_valid_r || out_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.random_value = out_value_r;
  assign out_ch.bound_error  = out_err_r;

  // A bound with a single bit set takes the scaled path instead of the remainder.
  assign in_pow = ((in_ch.upper_bound & (in_ch.upper_bound - lcgbri_pkg::VAL_W'(1))) == '0);

  // Power-of-two scaling: (bound * bits) >> 31.
  assign scaled = (2*lcgbri_pkg::VAL_W)'(bound_r) * (2*lcgbri_pkg::VAL_W)'(bits_r);

  // The draw is rejected when q*bound + bound - 1 reaches bit 31, that is
  // when (bits - val) + bound is strictly above 2^31.
  assign reject = alu_rsp.sum[31] && (alu_rsp.sum[30:0] != '0);

  // Operand selection for the shared adder in each step of the sequence.
  always_comb begin
    alu_req = '0;
    case (state_r)
      ST_MUL: begin
        alu_req.a   = {acc_r[lcgbri_pkg::STATE_W-2:0], 1'b0};
        alu_req.b   = lcgbri_pkg::LCG_MULT[cnt_r] ? lcg_r : '0;
        alu_req.sub = 1'b0;
      end
      ST_INC: begin
        alu_req.a   = acc_r;
        alu_req.b   = lcgbri_pkg::LCG_INC;
        alu_req.sub = 1'b0;
      end
      ST_DIV: begin
        alu_req.a   = {16'b0, acc_r[30:0], bits_r[cnt_r[4:0]]};
        alu_req.b   = {17'b0, bound_r};
        alu_req.sub = 1'b1;
      end
      ST_CHK_SUB: begin
        alu_req.a   = {17'b0, bits_r};
        alu_req.b   = acc_r;
        alu_req.sub = 1'b1;
      end
      ST_CHK_ADD: begin
        alu_req.a   = acc_r;
        alu_req.b   = {17'b0, bound_r};
        alu_req.sub = 1'b0;
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lcg_r       <= SEED_XOR;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      cnt_r       <= '0;
    end else begin
      // In ST_DONE the hand-off below decides the output register instead.
      if (out_valid_r && out_ch.ready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            bound_r  <= in_ch.upper_bound;
            pow_r    <= in_pow;
            result_r <= '0;
            err_r    <= (in_ch.upper_bound == '0);
            if (in_ch.upper_bound == '0 || in_ch.upper_bound == lcgbri_pkg::VAL_W'(1)) begin
              state_r <= ST_DONE;
            end else begin
              acc_r   <= '0;
              cnt_r   <= lcgbri_pkg::CNT_W'(lcgbri_pkg::MULT_BITS - 1);
              state_r <= ST_MUL;
            end
          end
        end

        // Horner-style multiply: one multiplier bit per cycle, MSB first.
        ST_MUL: begin
          acc_r <= alu_rsp.sum;
          if (cnt_r == '0) begin
            state_r <= ST_INC;
          end else begin
            cnt_r <= cnt_r - lcgbri_pkg::CNT_W'(1);
          end
        end

        ST_INC: begin
          if (!cfg_we) begin
            lcg_r <= alu_rsp.sum;
          end
          bits_r <= alu_rsp.sum[lcgbri_pkg::STATE_W-1:lcgbri_pkg::DRAW_SHIFT];
          if (pow_r) begin
            state_r <= ST_POW;
          end else begin
            acc_r   <= '0;
            cnt_r   <= lcgbri_pkg::CNT_W'(lcgbri_pkg::VAL_W - 1);
            state_r <= ST_DIV;
          end
        end

        ST_POW: begin
          result_r <= scaled[2*lcgbri_pkg::VAL_W-1:lcgbri_pkg::VAL_W];
          state_r  <= ST_DONE;
        end

        // Restoring remainder: keep the difference unless it went negative.
        ST_DIV: begin
          if (alu_rsp.sum[lcgbri_pkg::STATE_W-1]) begin
            acc_r <= {16'b0, alu_req.a[31:0]};
          end else begin
            acc_r <= alu_rsp.sum;
          end
          if (cnt_r == '0) begin
            state_r <= ST_CHK_SUB;
          end else begin
            cnt_r <= cnt_r - lcgbri_pkg::CNT_W'(1);
          end
        end

        ST_CHK_SUB: begin
          result_r <= acc_r[lcgbri_pkg::VAL_W-1:0];
          acc_r    <= alu_rsp.sum;
          state_r  <= ST_CHK_ADD;
        end

        ST_CHK_ADD: begin
          if (reject) begin
            acc_r   <= '0;
            cnt_r   <= lcgbri_pkg::CNT_W'(lcgbri_pkg::MULT_BITS - 1);
            state_r <= ST_MUL;
          end else begin
            state_r <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_value_r <= result_r;
            out_err_r   <= err_r;
            state_r     <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      if (cfg_we) begin
        lcg_r <= cfg_wdata ^ SEED_XOR;
      end
    end
  end

  // The running remainder never reaches the bound.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (acc_r[47:31] == '0) && (acc_r[30:0] < bound_r))
    else $error("remainder out of range during division");

  // A finished result always lies below its bound unless the bound was zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !err_r) |-> (result_r < bound_r))
    else $error("result not below bound");

  // An error beat carries a zero value.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_value_r == '0))
    else $error("bound error with nonzero value");

  // The generator does not move while a result waits to be handed off.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !cfg_we) |=> $stable(lcg_r))
    else $error("generator state changed while holding a result");

  // The multiply counter stays within the multiplier width.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (cnt_r < lcgbri_pkg::CNT_W'(lcgbri_pkg::MULT_BITS)))
    else $error("multiply bit counter out of range");

endmodule

FILE: bench/lcg48_bounded_random_int_test.sv
// Self-checking bench for the bounded random integer block on its 48-bit LCG.
module lcg48_bounded_random_int_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Generator constants, kept here so the prediction owes nothing to the RTL.
  localparam logic [lcgbri_pkg::STATE_W-1:0] GEN_MULT = 48'h5DEECE66D;
  localparam logic [lcgbri_pkg::STATE_W-1:0] GEN_ADD  = 48'hB;
  localparam int IDLE_PCT   = 19;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYC  = 120;

  typedef struct packed {
    logic [lcgbri_pkg::VAL_W-1:0] value;
    logic                         err;
  } draw_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [lcgbri_pkg::STATE_W-1:0] cfg_wdata;
  logic rx_ready = 1'b0;

  lcgbri_in_if  in_ch ();
  lcgbri_out_if out_ch ();

  assign out_ch.ready = rx_ready;

  lcg48_bounded_random_int dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #10 clk = ~clk;

  // Predicted generator state and the queue of draws still owed by the block.
  logic [lcgbri_pkg::STATE_W-1:0] gen_state;
  draw_t                          pending_draws[$];

  // When set, neither side inserts idle cycles.
  bit steady = 1'b0;

  int fail_count   = 0;
  int result_count = 0;
  int seed_count   = 0;
  int n_zero = 0, n_one = 0, n_pow2 = 0, n_other = 0;
  int quiet_cycles = 0;

  // One generator step: advance the state modulo 2^48 and return the top 31 bits.
  function automatic logic [lcgbri_pkg::VAL_W-1:0] gen_step();
    gen_state = gen_state * GEN_MULT + GEN_ADD;
    return gen_state[lcgbri_pkg::STATE_W-1:lcgbri_pkg::DRAW_SHIFT];
  endfunction

  // Works out the answer for one bound and moves the predicted state along.
  // A zero bound flags an error, a bound of one answers zero, both without
  // stepping. A power of two scales one draw. Any other bound reduces the draw
  // and rejects it when the 32-bit overflow test comes out negative.
  function automatic draw_t bounded_draw(input logic [lcgbri_pkg::VAL_W-1:0] bound);
    draw_t                        r;
    logic [lcgbri_pkg::VAL_W-1:0] bits;
    logic [31:0]                  rem;
    logic [31:0]                  test;
    logic [63:0]                  prod;
    r = '0;
    if (bound == '0) begin
      r.err = 1'b1;
    end else if (bound == 1) begin
      r.value = '0;
    end else if ((bound & (bound - 1'b1)) == '0) begin
      bits = gen_step();
      prod = 64'(bound) * 64'(bits);
      r.value = prod[61:31];
    end else begin
      do begin
        bits = gen_step();
        rem  = 32'(bits) % 32'(bound);
        test = 32'(bits) - rem + 32'(bound) - 32'd1;
      end while (test[31]);
      r.value = rem[lcgbri_pkg::VAL_W-1:0];
    end
    return r;
  endfunction

  // Receiver: ready drops in about one cycle in five unless the run is steady.
  always @(posedge clk) begin
    rx_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Result checker: every accepted out beat is matched against the oldest draw.
  always @(posedge clk) begin
    draw_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      result_count++;
      if (pending_draws.size() == 0) begin
        $display("%0t: unexpected result beat value=%h err=%b", $time,
                 out_ch.random_value, out_ch.bound_error);
        fail_count++;
      end else begin
        want = pending_draws.pop_front();
        if (out_ch.random_value !== want.value) begin
          $display("%0t: random_value mismatch expected %h actual %h", $time,
                   want.value, out_ch.random_value);
          fail_count++;
        end
        if (out_ch.bound_error !== want.err) begin
          $display("%0t: bound_error mismatch expected %b actual %b", $time,
                   want.err, out_ch.bound_error);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: a long spell with no beat on either channel ends the run.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
        $display("[lcg48_bounded_random_int] ERROR");
        $finish;
      end
    end
  end

  // Sends one bound. Valid stays high from the previous beat unless a gap is
  // taken, so it is never lowered and raised within the same edge.
  task automatic send_bound(input logic [lcgbri_pkg::VAL_W-1:0] bound);
    int    gap;
    draw_t predicted;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) gap++;
      // Now and then a long pause, so gaps also land on the busy stretches.
      if ($urandom_range(99) < 4) gap += $urandom_range(80, 1);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.upper_bound <= bound;
    do @(posedge clk); while (!in_ch.ready);
    predicted = bounded_draw(bound);
    pending_draws = {pending_draws, predicted};
    if (bound == '0) n_zero++;
    else if (bound == 1) n_one++;
    else if ((bound & (bound - 1'b1)) == '0) n_pow2++;
    else n_other++;
  endtask

  // Reseeds only once the block has returned every draw it owes.
  task automatic write_seed(input logic [lcgbri_pkg::STATE_W-1:0] seed);
    in_ch.valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= seed;
    @(posedge clk);
    cfg_we <= 1'b0;
    gen_state = seed ^ GEN_MULT;
    seed_count++;
  endtask

  // Bound mix for the random part: every class the block distinguishes, with
  // large bounds close to a power of two to push the rejection rate up.
  function automatic logic [lcgbri_pkg::VAL_W-1:0] pick_bound();
    int k;
    int sel;
    logic [lcgbri_pkg::VAL_W-1:0] b;
    sel = $urandom_range(99);
    k   = $urandom_range(30);
    if (sel < 8) b = '0;
    else if (sel < 16) b = 31'd1;
    else if (sel < 34) b = 31'd1 << k;
    else if (sel < 54) b = 31'($urandom_range(1000, 2));
    else if (sel < 76) b = 31'($urandom);
    else if (sel < 88) b = (31'd1 << 30) + 31'($urandom_range(1000));
    else b = (31'd1 << k) + 31'($urandom_range(2)) - 31'd1;
    return b;
  endfunction

  // Extremes of the bound and each case the block treats on its own, from the
  // reset seed.
  task automatic test_directed_bounds();
    send_bound(31'd0);
    send_bound(31'd1);
    send_bound(31'd2);
    send_bound(31'd3);
    send_bound(31'd4);
    send_bound(31'd5);
    send_bound(31'd7);
    send_bound(31'd1000);
    send_bound(31'h4000_0000);
    send_bound(31'h4000_0001);
    send_bound(31'h5555_5555);
    send_bound(31'h2AAA_AAAA);
    send_bound(31'h7FFF_FFFF);
    send_bound(31'h7FFF_FFFE);
    send_bound(31'h6000_0001);
    send_bound(31'd0);
    send_bound(31'd1);
    send_bound(31'h0001_0000);
  endtask

  // Seeds at the ends of the range, including the one that zeroes the state.
  task automatic test_seed_extremes();
    write_seed(48'h0);
    send_bound(31'h7FFF_FFFF);
    send_bound(31'd6);
    write_seed(48'hFFFF_FFFF_FFFF);
    send_bound(31'h4000_0001);
    send_bound(31'h0000_0400);
    write_seed(GEN_MULT);
    send_bound(31'd10);
    send_bound(31'h4000_0000);
    send_bound(31'd0);
  endtask

  // Random bounds over several random seeds with both sides idling at random.
  task automatic test_random_bounds(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      write_seed(lcgbri_pkg::STATE_W'({$urandom, $urandom}));
      for (int i = 0; i < per_phase; i++) send_bound(pick_bound());
    end
  endtask

  // One long stretch with no idling on either side, to run items back to back.
  task automatic test_back_to_back(input int count);
    write_seed(lcgbri_pkg::STATE_W'({$urandom, $urandom}));
    steady = 1'b1;
    for (int i = 0; i < count; i++) send_bound(pick_bound());
    steady = 1'b0;
  endtask

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.upper_bound <= '0;
    gen_state = 48'h0 ^ GEN_MULT;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_bounds();
    test_seed_extremes();
    test_random_bounds(4, 200);
    test_back_to_back(300);
    test_random_bounds(3, 200);
    write_seed(48'hFFFF_FFFF_FFFF);
    for (int i = 0; i < 100; i++) send_bound(pick_bound());

    in_ch.valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Sent %0d bounds: %0d zero, %0d one, %0d power of two, %0d other.",
             n_zero + n_one + n_pow2 + n_other, n_zero, n_one, n_pow2, n_other);
    $display("Checked %0d result beats across %0d seed writes.", result_count,
             seed_count);
    if (fail_count == 0) begin
      $display("[lcg48_bounded_random_int] OK");
    end else begin
      $display("[lcg48_bounded_random_int] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/lcgbri_pkg.sv
hdl/lcgbri_if.sv
hdl/lcgbri_alu.sv
hdl/lcg48_bounded_random_int.sv
bench/lcg48_bounded_random_int_test.sv
